@@ sv/apt_pkg.sv @@
// Shared constants, register codes and lane result type for the affine point transform.
`default_nettype none

package apt_pkg;

  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_COORD_WIDTH = 32;
  localparam int COEF_WIDTH      = 32;
  localparam int OUT_COORD_WIDTH = 32;
  localparam int NUM_ROWS        = 3;
  localparam int NUM_CFG_REGS    = 6;
  localparam int CFG_IDX_WIDTH   = 3;
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int IN_DATA_WIDTH   = 96;
  localparam int OUT_DATA_WIDTH  = 96;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5
  } cfg_idx_t;

  // One row's finished coordinate, sign-extended to the output width, with its saturation flag.
  typedef struct packed {
    logic [OUT_COORD_WIDTH-1:0] coord;
    logic                       sat;
  } lane_res_t;

endpackage

`default_nettype wire

@@ sv/apt_lane.sv @@
// One matrix row: three products, floor shift, sum with translation, saturate.
`default_nettype none

module apt_lane #(
  parameter int FRAC_BITS   = apt_pkg::DEF_FRAC_BITS,
  parameter int COORD_WIDTH = apt_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 advance,
  input  wire logic signed [COORD_WIDTH-1:0]        pos_x,
  input  wire logic signed [COORD_WIDTH-1:0]        pos_y,
  input  wire logic signed [COORD_WIDTH-1:0]        pos_z,
  input  wire logic signed [apt_pkg::COEF_WIDTH-1:0] coef0,
  input  wire logic signed [apt_pkg::COEF_WIDTH-1:0] coef1,
  input  wire logic signed [apt_pkg::COEF_WIDTH-1:0] coef2,
  input  wire logic signed [apt_pkg::COEF_WIDTH-1:0] coef3,
  output apt_pkg::lane_res_t                        res
);

  localparam int PW = apt_pkg::COEF_WIDTH + COORD_WIDTH;
  localparam int SW = PW + 2;

  localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic signed [PW-1:0]          p0_r, p1_r, p2_r;
  logic signed [PW-1:0]          p0_nxt, p1_nxt, p2_nxt;
  logic signed [SW-1:0]          sum;
  logic signed [COORD_WIDTH-1:0] sat_val;
  logic                          sat;
  apt_pkg::lane_res_t            res_r, res_nxt;

  always_comb begin
    p0_nxt = PW'(coef0) * PW'(pos_x);
    p1_nxt = PW'(coef1) * PW'(pos_y);
    p2_nxt = PW'(coef2) * PW'(pos_z);
  end

  // Arithmetic shift gives the floor; translation enters unshifted.
  always_comb begin
    sum = SW'(p0_r >>> FRAC_BITS) + SW'(p1_r >>> FRAC_BITS)
        + SW'(p2_r >>> FRAC_BITS) + SW'(coef3);
    if (sum > MAXV) begin
      sat_val = MAXV[COORD_WIDTH-1:0];
      sat     = 1'b1;
    end else if (sum < MINV) begin
      sat_val = MINV[COORD_WIDTH-1:0];
      sat     = 1'b1;
    end else begin
      sat_val = sum[COORD_WIDTH-1:0];
      sat     = 1'b0;
    end
    res_nxt.coord = apt_pkg::OUT_COORD_WIDTH'(sat_val);
    res_nxt.sat   = sat;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

@@ sv/apt_merge.sv @@
// Output stage: joins the three lane results, ORs the saturation flags, holds the beat.
`default_nettype none

module apt_merge (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  res_valid,
  input  wire apt_pkg::lane_res_t                    res_x,
  input  wire apt_pkg::lane_res_t                    res_y,
  input  wire apt_pkg::lane_res_t                    res_z,
  input  wire logic                                  res_last,
  output logic                                       advance,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [apt_pkg::OUT_DATA_WIDTH-1:0]         out_tdata,
  output logic                                       out_tuser,
  output logic                                       out_tlast
);

  logic                              valid_r, valid_nxt;
  logic [apt_pkg::OUT_DATA_WIDTH-1:0] data_r;
  logic                              ovf_r, last_r;

  // The whole pipe moves whenever the output slot is empty or being drained.
  assign advance   = !valid_r || out_tready;
  assign valid_nxt = advance ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= {res_z.coord, res_y.coord, res_x.coord};
      ovf_r  <= res_x.sat | res_y.sat | res_z.sat;
      last_r <= res_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = ovf_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

@@ sv/affine_point_transform_unit.sv @@
// Affine 3D point transform top level: config registers, three row lanes and output merge.
//
// Usage:
//   in_*  : one point per beat. in_tdata holds pos_x [31:0], pos_y [63:32], pos_z [95:64],
//           signed Q16.16; in_tlast marks the final point of an object.
//   out_* : one result per point, in order. out_tdata holds x [31:0], y [63:32], z [95:64],
//           saturated; out_tuser is the overflow flag; out_tlast copies in_tlast.
//   cfg_* : write register cfg_index (0..5, row r columns 0/1 at 2r, columns 2/3 at 2r+1)
//           with cfg_data; cfg_ready is always high, other indexes are dropped. Write only
//           while no point is in flight.
// Timing: an accepted point passes through the product register, the sum/saturate register and
//   the output register, which drives out_tvalid, in that order. One point per cycle is sustained
//   while the output register is empty or being taken; each row lane has three
//   multipliers running in parallel.
// Reset: clears all valid bits and loads the identity matrix.
// Stall: with out_tvalid high and out_tready low the whole pipe holds and in_tready drops;
//   in_tready stays high while the output register is empty or being taken.
`default_nettype none

module affine_point_transform_unit #(
  parameter int FRAC_BITS   = apt_pkg::DEF_FRAC_BITS,
  parameter int COORD_WIDTH = apt_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [apt_pkg::IN_DATA_WIDTH-1:0]     in_tdata,  // pos_x, pos_y, pos_z
  input  wire logic                                  in_tlast,  // last_point
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [apt_pkg::OUT_DATA_WIDTH-1:0]         out_tdata, // out_x, out_y, out_z
  output logic                                       out_tuser, // overflow
  output logic                                       out_tlast, // last_out
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [apt_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  wire logic [apt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

  localparam int CW = apt_pkg::COEF_WIDTH;
  localparam logic [apt_pkg::CFG_DATA_WIDTH-1:0] ONE =
    apt_pkg::CFG_DATA_WIDTH'(64'd1 << FRAC_BITS);
  localparam logic signed [apt_pkg::OUT_COORD_WIDTH-1:0] OUT_MAX =
    apt_pkg::OUT_COORD_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [apt_pkg::OUT_COORD_WIDTH-1:0] OUT_MIN = -OUT_MAX - 1;

  logic [apt_pkg::CFG_DATA_WIDTH-1:0] cfg_r [apt_pkg::NUM_CFG_REGS];
  logic                               advance;
  logic                               v1_r, v2_r;
  logic                               last1_r, last2_r;
  logic signed [COORD_WIDTH-1:0]      pos_x, pos_y, pos_z;
  apt_pkg::lane_res_t                 lane_res [apt_pkg::NUM_ROWS];

  assign cfg_ready = 1'b1;
  assign in_tready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= ONE;
      cfg_r[1] <= '0;
      cfg_r[2] <= ONE << CW;
      cfg_r[3] <= '0;
      cfg_r[4] <= '0;
      cfg_r[5] <= ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        apt_pkg::REG_ROW0_COLS01: cfg_r[0] <= cfg_data;
        apt_pkg::REG_ROW0_COLS23: cfg_r[1] <= cfg_data;
        apt_pkg::REG_ROW1_COLS01: cfg_r[2] <= cfg_data;
        apt_pkg::REG_ROW1_COLS23: cfg_r[3] <= cfg_data;
        apt_pkg::REG_ROW2_COLS01: cfg_r[4] <= cfg_data;
        apt_pkg::REG_ROW2_COLS23: cfg_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Upper bits of each coordinate beyond COORD_WIDTH are ignored.
  assign pos_x = $signed(in_tdata[COORD_WIDTH-1:0]);
  assign pos_y = $signed(in_tdata[32+COORD_WIDTH-1:32]);
  assign pos_z = $signed(in_tdata[64+COORD_WIDTH-1:64]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      last1_r <= in_tlast;
      last2_r <= last1_r;
    end
  end

  for (genvar r = 0; r < apt_pkg::NUM_ROWS; r++) begin : g_lane
    apt_lane #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk    (clk),
      .advance(advance),
      .pos_x  (pos_x),
      .pos_y  (pos_y),
      .pos_z  (pos_z),
      .coef0  ($signed(cfg_r[2*r][CW-1:0])),
      .coef1  ($signed(cfg_r[2*r][2*CW-1:CW])),
      .coef2  ($signed(cfg_r[2*r+1][CW-1:0])),
      .coef3  ($signed(cfg_r[2*r+1][2*CW-1:CW])),
      .res    (lane_res[r])
    );
  end

  apt_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (v2_r),
    .res_x     (lane_res[0]),
    .res_y     (lane_res[1]),
    .res_z     (lane_res[2]),
    .res_last  (last2_r),
    .advance   (advance),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // An accepted beat always lands in the product stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted point missing from product stage");

  // A stall freezes the in-flight valid bits.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(v1_r) && $stable(v2_r)))
    else $error("pipeline moved during stall");

  // Overflow only with some coordinate clamped to a bound.
  a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      ($signed(out_tdata[31:0])  == OUT_MAX || $signed(out_tdata[31:0])  == OUT_MIN ||
       $signed(out_tdata[63:32]) == OUT_MAX || $signed(out_tdata[63:32]) == OUT_MIN ||
       $signed(out_tdata[95:64]) == OUT_MAX || $signed(out_tdata[95:64]) == OUT_MIN))
    else $error("overflow flagged without a clamped coordinate");

  // A write to the first row register lands on the next edge.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == apt_pkg::REG_ROW0_COLS01) |=>
      (cfg_r[0] == $past(cfg_data)))
    else $error("config write lost");

endmodule

`default_nettype wire

@@ test/affine_point_transform_unit_tb.sv @@
// Testbench for the affine point transform unit: predicts each transformed point and checks it.
module affine_point_transform_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          IDLE_LIMIT = 4000;
  localparam logic [31:0] C_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN      = 32'h8000_0000;
  localparam logic [31:0] C_NEG1     = 32'hFFFF_FFFF;
  localparam logic [31:0] C_ONE      = 32'(1) << apt_pkg::DEF_FRAC_BITS;
  localparam logic [31:0] C_HALF     = 32'(1) << (apt_pkg::DEF_FRAC_BITS - 1);

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        ovf;
    logic        last;
  } point_res_t;

  // Matrix copy, expected-point queue and result checks.
  class xform_board;
    logic [63:0] coef_regs [apt_pkg::NUM_CFG_REGS];
    point_res_t  expected_points [$];
    int          errors;
    int          checked;
    int          sat_count;
    int          last_count;

    function new();
      coef_regs[apt_pkg::REG_ROW0_COLS01] = 64'(C_ONE);
      coef_regs[apt_pkg::REG_ROW0_COLS23] = '0;
      coef_regs[apt_pkg::REG_ROW1_COLS01] = {C_ONE, 32'h0};
      coef_regs[apt_pkg::REG_ROW1_COLS23] = '0;
      coef_regs[apt_pkg::REG_ROW2_COLS01] = '0;
      coef_regs[apt_pkg::REG_ROW2_COLS23] = 64'(C_ONE);
    endfunction

    function void set_reg(logic [apt_pkg::CFG_IDX_WIDTH-1:0] idx, logic [63:0] val);
      // drop writes to unused indexes
      if (idx < apt_pkg::NUM_CFG_REGS) coef_regs[idx] = val;
    endfunction

    // Exact row sum: each product floored by the fraction shift, translation added as is.
    function longint row_sum(int r, longint px, longint py, longint pz);
      logic [63:0] lo;
      logic [63:0] hi;
      lo = coef_regs[2*r];
      hi = coef_regs[2*r+1];
      return ((longint'($signed(lo[31:0])) * px) >>> apt_pkg::DEF_FRAC_BITS)
           + ((longint'($signed(lo[63:32])) * py) >>> apt_pkg::DEF_FRAC_BITS)
           + ((longint'($signed(hi[31:0])) * pz) >>> apt_pkg::DEF_FRAC_BITS)
           + longint'($signed(hi[63:32]));
    endfunction

    function logic [31:0] clamp(longint s, inout bit ovf);
      longint hi_lim;
      longint lo_lim;
      hi_lim = (longint'(1) <<< (apt_pkg::DEF_COORD_WIDTH - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (s > hi_lim) begin
        ovf = 1'b1;
        return hi_lim[31:0];
      end
      if (s < lo_lim) begin
        ovf = 1'b1;
        return lo_lim[31:0];
      end
      return s[31:0];
    endfunction

    function void note_point(logic [apt_pkg::IN_DATA_WIDTH-1:0] d, logic last);
      longint     px;
      longint     py;
      longint     pz;
      bit         ovf;
      point_res_t e;
      px = longint'($signed(d[31:0]));
      py = longint'($signed(d[63:32]));
      pz = longint'($signed(d[95:64]));
      ovf = 1'b0;
      e.x = clamp(row_sum(0, px, py, pz), ovf);
      e.y = clamp(row_sum(1, px, py, pz), ovf);
      e.z = clamp(row_sum(2, px, py, pz), ovf);
      e.ovf = ovf;
      e.last = last;
      expected_points.push_back(e);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_result(logic [apt_pkg::OUT_DATA_WIDTH-1:0] d, logic ovf, logic last);
      point_res_t e;
      if (expected_points.size() == 0) begin
        flag("unexpected result", 'x, d[31:0]);
        return;
      end
      e = expected_points.pop_front();
      checked++;
      if (e.ovf) sat_count++;
      if (e.last) last_count++;
      if (d[31:0] !== e.x) flag("out_x", e.x, d[31:0]);
      if (d[63:32] !== e.y) flag("out_y", e.y, d[63:32]);
      if (d[95:64] !== e.z) flag("out_z", e.z, d[95:64]);
      if (ovf !== e.ovf) flag("overflow", 32'(e.ovf), 32'(ovf));
      if (last !== e.last) flag("last_out", 32'(e.last), 32'(last));
    endfunction
  endclass

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               in_tvalid  = 1'b0;
  logic                               in_tready;
  logic [apt_pkg::IN_DATA_WIDTH-1:0]  in_tdata   = '0;
  logic                               in_tlast   = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [apt_pkg::OUT_DATA_WIDTH-1:0] out_tdata;
  logic                               out_tuser;
  logic                               out_tlast;
  logic                               cfg_valid  = 1'b0;
  logic                               cfg_ready;
  logic [apt_pkg::CFG_IDX_WIDTH-1:0]  cfg_index  = '0;
  logic [apt_pkg::CFG_DATA_WIDTH-1:0] cfg_data   = '0;

  xform_board sb;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         idle_cycles   = 0;
  int         matrix_loads  = 0;

  affine_point_transform_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sample every handshake at the edge; restart the watchdog on any beat.
  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_point(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
    end
    idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("affine_point_transform_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [apt_pkg::IN_DATA_WIDTH-1:0] pack_point(logic [31:0] x,
                                                                   logic [31:0] y,
                                                                   logic [31:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(5))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return 32'h0;
      3:       return C_NEG1;
      4:       return 32'h1;
      default: return C_ONE;
    endcase
  endfunction

  // kind 0: within +/-4.0, kind 1: any value, otherwise an extreme
  function automatic logic [31:0] pick_coef(int kind);
    if (kind == 0) return 32'($urandom_range(32'h8_0000)) - 32'h4_0000;
    if (kind == 1) return $urandom;
    return pick_extreme();
  endfunction

  function automatic logic [31:0] pick_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 32'($urandom_range(32'h20_0000)) - 32'h10_0000;
    if (sel < 85) return $urandom;
    return pick_extreme();
  endfunction

  task automatic send_point(input logic [apt_pkg::IN_DATA_WIDTH-1:0] d, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off the input until every expected point has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [apt_pkg::CFG_IDX_WIDTH-1:0] idx,
                         input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_matrix(input logic [63:0] m [apt_pkg::NUM_CFG_REGS], input bit stray);
    logic [apt_pkg::CFG_IDX_WIDTH-1:0] idx;
    for (int r = 0; r < apt_pkg::NUM_CFG_REGS; r++) put_reg(apt_pkg::cfg_idx_t'(r), m[r]);
    if (stray) begin
      for (int k = apt_pkg::NUM_CFG_REGS; k < (1 << apt_pkg::CFG_IDX_WIDTH); k++) begin
        idx = apt_pkg::CFG_IDX_WIDTH'(k);
        put_reg(idx, {$urandom, $urandom});
      end
    end
    cfg_valid <= 1'b0;
    matrix_loads++;
  endtask

  initial begin
    logic [63:0] m [apt_pkg::NUM_CFG_REGS];
    int          kind;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity after reset: extremes pass straight through.
    send_point(pack_point(32'h0, 32'h0, 32'h0), 1'b0);
    send_point(pack_point(C_MAX, C_MAX, C_MAX), 1'b0);
    send_point(pack_point(C_MIN, C_MIN, C_MIN), 1'b1);
    send_point(pack_point(C_NEG1, 32'h1, 32'h0001_8000), 1'b0);
    send_point(pack_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F), 1'b1);
    drain();

    // Largest coefficients and translation: saturate high and low.
    m = '{default: {C_MAX, C_MAX}};
    load_matrix(m, 1'b0);
    send_point(pack_point(C_MAX, C_MAX, C_MAX), 1'b0);
    send_point(pack_point(C_MIN, C_MIN, C_MIN), 1'b1);
    send_point(pack_point(32'h0, 32'h0, 32'h0), 1'b0);
    drain();

    // Most negative coefficients: min times min is the largest product.
    m = '{default: {C_MIN, C_MIN}};
    load_matrix(m, 1'b0);
    send_point(pack_point(C_MIN, C_MIN, C_MIN), 1'b0);
    send_point(pack_point(C_MAX, C_MAX, C_MAX), 1'b1);
    send_point(pack_point(32'h1, 32'h1, 32'h1), 1'b0);
    drain();

    // Negative products floor toward minus infinity; stray indexes must be dropped.
    m[apt_pkg::REG_ROW0_COLS01] = {C_HALF, C_NEG1};
    m[apt_pkg::REG_ROW0_COLS23] = {32'h0, -C_HALF};
    m[apt_pkg::REG_ROW1_COLS01] = {-C_ONE, C_HALF};
    m[apt_pkg::REG_ROW1_COLS23] = {C_NEG1, C_NEG1};
    m[apt_pkg::REG_ROW2_COLS01] = {C_NEG1, -C_HALF};
    m[apt_pkg::REG_ROW2_COLS23] = {32'h1, C_HALF};
    load_matrix(m, 1'b1);
    send_point(pack_point(32'h1, C_NEG1, 32'h1), 1'b0);
    send_point(pack_point(C_NEG1, 32'h1, C_NEG1), 1'b0);
    send_point(pack_point(32'h3, -32'h3, C_MAX), 1'b0);
    send_point(pack_point(C_MIN, C_MIN, C_MIN), 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      case (ph / 4)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int r = 0; r < apt_pkg::NUM_CFG_REGS; r++) begin
        kind = (ph % 4 == 3) ? $urandom_range(2) : ph % 4;
        m[r] = {pick_coef(kind), pick_coef(kind)};
      end
      load_matrix(m, ph % 3 == 0);
      for (int i = 0; i < 100; i++) begin
        if (i == 50 && ph % 4 == 1) drain();
        send_point(pack_point(pick_coord(), pick_coord(), pick_coord()),
                   $urandom_range(7) == 0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.expected_points.size() != 0) begin
      $display("%0t: %0d expected points never came out", $time, sb.expected_points.size());
      sb.errors += sb.expected_points.size();
    end
    $display("Checked %0d points under %0d matrix settings; %0d saturated, %0d object ends.",
             sb.checked, matrix_loads, sb.sat_count, sb.last_count);
    $display("Stalls were mixed sender-heavy, receiver-heavy and off; %0d mismatches seen.",
             sb.errors);
    if (sb.errors == 0) begin
      $display("affine_point_transform_unit_tb: PASS");
    end else begin
      $display("affine_point_transform_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
